// ===== hdl/bt_pkg.sv =====
// ----------------------------------------------------------------------------
// bt_pkg
// shared constants, codes and controller/datapath types of the trie multiset
// ----------------------------------------------------------------------------
`default_nettype none

package bt_pkg;

  localparam int KEY_BITS   = 16;
  localparam int COUNT_BITS = 32;
  localparam int NODE_BITS  = KEY_BITS + 1;
  localparam int NODE_DEPTH = 1 << NODE_BITS;

  typedef logic [NODE_BITS-1:0]  node_t;
  typedef logic [KEY_BITS-1:0]   bkey_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  // largest count that fits, one bit wider than any 32-bit sum
  localparam logic [32:0] COUNT_MAX = (33'd1 << COUNT_BITS) - 33'd1;

  // request codes
  localparam logic [3:0] OP_INSERT      = 4'd0;
  localparam logic [3:0] OP_ERASE       = 4'd1;
  localparam logic [3:0] OP_COUNT       = 4'd2;
  localparam logic [3:0] OP_KTH_SMALL   = 4'd3;
  localparam logic [3:0] OP_ERASE_SMALL = 4'd4;
  localparam logic [3:0] OP_KTH_GREAT   = 4'd5;
  localparam logic [3:0] OP_ERASE_GREAT = 4'd6;
  localparam logic [3:0] OP_CNT_SMALLER = 4'd7;
  localparam logic [3:0] OP_CNT_GREATER = 4'd8;
  localparam logic [3:0] OP_MIN_XOR     = 4'd9;
  localparam logic [3:0] OP_MAX_XOR     = 4'd10;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // datapath commands
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_RD_ROOT,
    CMD_RD_LEAF,
    CMD_CHECK,
    CMD_WRD,
    CMD_WUSE,
    CMD_FRD,
    CMD_FUSE,
    CMD_PSTART,
    CMD_PRD,
    CMD_PWR,
    CMD_SHOW
  } cmd_t;

  // what follows the check of a request
  typedef enum logic [1:0] {
    DEC_DONE,
    DEC_PATH,
    DEC_WALK
  } dec_t;

  // what follows the end of a walk
  typedef enum logic [1:0] {
    WEND_DONE,
    WEND_FINAL,
    WEND_PATH
  } wend_t;

  typedef struct packed {
    logic  clr_last;
    dec_t  dec;
    wend_t wend;
    logic  at_last;
    logic  at_leaf;
    logic  out_free;
  } bt_sts_t;

endpackage

`default_nettype wire

// ===== hdl/bt_in_if.sv =====
// ----------------------------------------------------------------------------
// bt_in_if
// request channel: valid/ready handshake with the request payload
// ----------------------------------------------------------------------------
`default_nettype none

interface bt_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  req_type;
  logic [15:0] key;
  logic [31:0] amount;

  modport source (output valid, output req_type, output key, output amount, input ready);
  modport sink   (input valid, input req_type, input key, input amount, output ready);
endinterface

`default_nettype wire

// ===== hdl/bt_out_if.sv =====
// ----------------------------------------------------------------------------
// bt_out_if
// result channel: valid/ready handshake with the result payload
// ----------------------------------------------------------------------------
`default_nettype none

interface bt_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] value;
  logic [31:0] tally;
  logic [1:0]  status;

  modport source (output valid, output value, output tally, output status, input ready);
  modport sink   (input valid, input value, input tally, input status, output ready);
endinterface

`default_nettype wire

// ===== hdl/bt_ram.sv =====
// ----------------------------------------------------------------------------
// bt_ram
// generic memory, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module bt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hdl/bt_ctrl.sv =====
// ----------------------------------------------------------------------------
// bt_ctrl
// sequencer: clearing pass, request check, trie walk and path update
// ----------------------------------------------------------------------------
`default_nettype none

module bt_ctrl import bt_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire bt_sts_t sts,
  output cmd_t         cmd
);

  typedef enum logic [12:0] {
    S_CLEAR  = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_ROOT   = 13'b0000000000100,
    S_LEAF   = 13'b0000000001000,
    S_CHECK  = 13'b0000000010000,
    S_WRD    = 13'b0000000100000,
    S_WUSE   = 13'b0000001000000,
    S_FRD    = 13'b0000010000000,
    S_FUSE   = 13'b0000100000000,
    S_PSTART = 13'b0001000000000,
    S_PRD    = 13'b0010000000000,
    S_PWR    = 13'b0100000000000,
    S_DONE   = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd = CMD_CLEAR;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd       = CMD_LOAD;
          state_nxt = S_ROOT;
        end
      end
      S_ROOT: begin
        cmd       = CMD_RD_ROOT;
        state_nxt = S_LEAF;
      end
      S_LEAF: begin
        cmd       = CMD_RD_LEAF;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd = CMD_CHECK;
        case (sts.dec)
          DEC_PATH: state_nxt = S_PRD;
          DEC_WALK: state_nxt = S_WRD;
          default:  state_nxt = S_DONE;
        endcase
      end
      S_WRD: begin
        cmd       = CMD_WRD;
        state_nxt = S_WUSE;
      end
      S_WUSE: begin
        cmd = CMD_WUSE;
        if (sts.at_last) begin
          case (sts.wend)
            WEND_FINAL: state_nxt = S_FRD;
            WEND_PATH:  state_nxt = S_PSTART;
            default:    state_nxt = S_DONE;
          endcase
        end else begin
          state_nxt = S_WRD;
        end
      end
      S_FRD: begin
        cmd       = CMD_FRD;
        state_nxt = S_FUSE;
      end
      S_FUSE: begin
        cmd       = CMD_FUSE;
        state_nxt = S_DONE;
      end
      S_PSTART: begin
        cmd       = CMD_PSTART;
        state_nxt = S_PRD;
      end
      S_PRD: begin
        cmd       = CMD_PRD;
        state_nxt = S_PWR;
      end
      S_PWR: begin
        cmd       = CMD_PWR;
        state_nxt = sts.at_leaf ? S_DONE : S_PRD;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd       = CMD_SHOW;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/bt_dp.sv =====
// ----------------------------------------------------------------------------
// bt_dp
// datapath: count memory, walk registers, result and output registers
// ----------------------------------------------------------------------------
`default_nettype none

module bt_dp import bt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  output bt_sts_t          sts,
  input  wire logic [3:0]  in_req_type,
  input  wire logic [15:0] in_key,
  input  wire logic [31:0] in_amount,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [15:0] out_value,
  output logic      [31:0] out_tally,
  output logic      [1:0]  out_status
);

  logic [3:0]  op_r, op_nxt;
  bkey_t       key_r, key_nxt;
  logic [31:0] amt_r, amt_nxt;
  count_t      total_r, total_nxt;
  node_t       n_r, n_nxt;
  bkey_t       kr_r, kr_nxt;
  logic [31:0] k_r, k_nxt;
  count_t      sum_r, sum_nxt;
  bkey_t       res_r, res_nxt;
  count_t      delta_r, delta_nxt;
  logic        sub_r, sub_nxt;
  node_t       clr_r, clr_nxt;
  logic [15:0] w_value_r, w_value_nxt;
  logic [31:0] w_tally_r, w_tally_nxt;
  logic [1:0]  w_status_r, w_status_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_value_r, out_value_nxt;
  logic [31:0] out_tally_r, out_tally_nxt;
  logic [1:0]  out_status_r, out_status_nxt;

  logic   we;
  node_t  waddr, raddr;
  count_t wdata, rdata;

  bt_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NODE_DEPTH)
  ) u_counts (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // request class decode
  logic is_kth, is_kerase, is_cnt, is_xor, hi, maxi, b, pref, wbit, resbit;
  logic ovf, erase_big, bad_rank;
  count_t upd;

  assign is_kth    = op_r inside {OP_KTH_SMALL, OP_ERASE_SMALL, OP_KTH_GREAT, OP_ERASE_GREAT};
  assign is_kerase = op_r inside {OP_ERASE_SMALL, OP_ERASE_GREAT};
  assign is_cnt    = op_r inside {OP_CNT_SMALLER, OP_CNT_GREATER};
  assign is_xor    = op_r inside {OP_MIN_XOR, OP_MAX_XOR};
  assign hi        = op_r inside {OP_KTH_GREAT, OP_ERASE_GREAT};
  assign maxi      = (op_r == OP_MAX_XOR);
  assign b         = kr_r[KEY_BITS-1];
  assign pref      = b ^ maxi;

  assign ovf       = (33'(total_r) + 33'(amt_r)) > COUNT_MAX;
  assign erase_big = amt_r > 32'(rdata);
  assign bad_rank  = (amt_r == 32'd0) || (amt_r > 32'(total_r));
  assign upd       = sub_r ? (rdata - delta_r) : (rdata + delta_r);

  // child read during a walk
  always_comb begin
    if (is_kth) begin
      wbit = hi;
    end else if (is_cnt) begin
      wbit = (op_r == OP_CNT_GREATER);
    end else begin
      wbit = pref;
    end
  end

  always_comb begin
    sts.clr_last = &clr_r;
    sts.at_last  = n_r[KEY_BITS-1];
    sts.at_leaf  = n_r[KEY_BITS];
    sts.out_free = !out_valid_r || out_ready;
    case (op_r)
      OP_INSERT: sts.dec = ovf ? DEC_DONE : DEC_PATH;
      OP_ERASE:  sts.dec = erase_big ? DEC_DONE : DEC_PATH;
      OP_KTH_SMALL, OP_ERASE_SMALL, OP_KTH_GREAT, OP_ERASE_GREAT:
        sts.dec = bad_rank ? DEC_DONE : DEC_WALK;
      OP_CNT_SMALLER, OP_CNT_GREATER: sts.dec = DEC_WALK;
      OP_MIN_XOR, OP_MAX_XOR: sts.dec = (total_r == '0) ? DEC_DONE : DEC_WALK;
      default:   sts.dec = DEC_DONE;
    endcase
    if (is_kerase) begin
      sts.wend = WEND_PATH;
    end else if (is_cnt) begin
      sts.wend = WEND_FINAL;
    end else begin
      sts.wend = WEND_DONE;
    end
  end

  always_comb begin
    op_nxt         = op_r;
    key_nxt        = key_r;
    amt_nxt        = amt_r;
    total_nxt      = total_r;
    n_nxt          = n_r;
    kr_nxt         = kr_r;
    k_nxt          = k_r;
    sum_nxt        = sum_r;
    res_nxt        = res_r;
    delta_nxt      = delta_r;
    sub_nxt        = sub_r;
    clr_nxt        = clr_r;
    w_value_nxt    = w_value_r;
    w_tally_nxt    = w_tally_r;
    w_status_nxt   = w_status_r;
    out_value_nxt  = out_value_r;
    out_tally_nxt  = out_tally_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    resbit         = 1'b0;
    we             = 1'b0;
    waddr          = n_r;
    wdata          = upd;
    raddr          = n_r;

    case (cmd)
      CMD_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r;
        wdata   = '0;
        clr_nxt = clr_r + node_t'(1);
      end
      CMD_LOAD: begin
        op_nxt  = in_req_type;
        key_nxt = KEY_BITS'(32'(in_key));
        amt_nxt = in_amount;
      end
      CMD_RD_ROOT: begin
        raddr = node_t'(1);
      end
      CMD_RD_LEAF: begin
        total_nxt = rdata;
        raddr     = {1'b1, key_r};
      end
      CMD_CHECK: begin
        // rdata holds the key's leaf count
        n_nxt        = node_t'(1);
        kr_nxt       = key_r;
        k_nxt        = amt_r;
        sum_nxt      = '0;
        res_nxt      = '0;
        delta_nxt    = COUNT_BITS'(amt_r);
        sub_nxt      = (op_r == OP_ERASE);
        w_value_nxt  = '0;
        w_tally_nxt  = '0;
        w_status_nxt = ST_OK;
        case (op_r)
          OP_INSERT: if (ovf) w_status_nxt = ST_OVERFLOW;
          OP_ERASE:  if (erase_big) w_status_nxt = ST_RANGE;
          OP_COUNT:  w_tally_nxt = 32'(rdata);
          OP_KTH_SMALL, OP_ERASE_SMALL, OP_KTH_GREAT, OP_ERASE_GREAT:
            if (bad_rank) w_status_nxt = ST_RANGE;
          OP_MIN_XOR, OP_MAX_XOR:
            if (total_r == '0) w_status_nxt = ST_RANGE;
          default: ;
        endcase
      end
      CMD_WRD: begin
        raddr = {n_r[KEY_BITS-1:0], wbit};
      end
      CMD_WUSE: begin
        kr_nxt = kr_r << 1;
        if (is_kth) begin
          if (32'(rdata) >= k_r) begin
            n_nxt = {n_r[KEY_BITS-1:0], hi};
          end else begin
            k_nxt = k_r - 32'(rdata);
            n_nxt = {n_r[KEY_BITS-1:0], ~hi};
          end
        end else if (is_cnt) begin
          n_nxt = {n_r[KEY_BITS-1:0], b};
          if (b == (op_r == OP_CNT_SMALLER)) sum_nxt = sum_r + rdata;
        end else begin
          if (rdata != '0) begin
            n_nxt  = {n_r[KEY_BITS-1:0], pref};
            resbit = maxi;
          end else begin
            n_nxt  = {n_r[KEY_BITS-1:0], ~pref};
            resbit = ~maxi;
          end
          res_nxt = {res_r[KEY_BITS-2:0], resbit};
        end
        if (n_r[KEY_BITS-1]) begin
          if (is_kth) begin
            w_value_nxt = 16'(32'(n_nxt[KEY_BITS-1:0]));
          end else if (is_xor) begin
            w_value_nxt = 16'(32'(res_nxt));
          end
        end
      end
      CMD_FRD: begin
        raddr = n_r;
      end
      CMD_FUSE: begin
        // equal keys count only with an inclusive flag of one
        w_tally_nxt = 32'(sum_r + ((amt_r == 32'd1) ? rdata : '0));
      end
      CMD_PSTART: begin
        kr_nxt    = n_r[KEY_BITS-1:0];
        n_nxt     = node_t'(1);
        delta_nxt = count_t'(1);
        sub_nxt   = 1'b1;
      end
      CMD_PRD: begin
        raddr = n_r;
      end
      CMD_PWR: begin
        we    = 1'b1;
        waddr = n_r;
        wdata = upd;
        if (n_r[KEY_BITS]) begin
          if (op_r == OP_INSERT || op_r == OP_ERASE) w_tally_nxt = 32'(upd);
        end else begin
          n_nxt  = {n_r[KEY_BITS-1:0], b};
          kr_nxt = kr_r << 1;
        end
      end
      CMD_SHOW: begin
        out_valid_nxt  = 1'b1;
        out_value_nxt  = w_value_r;
        out_tally_nxt  = w_tally_r;
        out_status_nxt = w_status_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    amt_r        <= amt_nxt;
    total_r      <= total_nxt;
    n_r          <= n_nxt;
    kr_r         <= kr_nxt;
    k_r          <= k_nxt;
    sum_r        <= sum_nxt;
    res_r        <= res_nxt;
    delta_r      <= delta_nxt;
    sub_r        <= sub_nxt;
    w_value_r    <= w_value_nxt;
    w_tally_r    <= w_tally_nxt;
    w_status_r   <= w_status_nxt;
    out_value_r  <= out_value_nxt;
    out_tally_r  <= out_tally_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_tally  = out_tally_r;
  assign out_status = out_status_r;

endmodule

`default_nettype wire

// ===== hdl/bitwise_trie_multiset.sv =====
// ----------------------------------------------------------------------------
// bitwise_trie_multiset
// order-statistic multiset of keys kept as a binary trie of occurrence counts
// ----------------------------------------------------------------------------
// sequence: load, root read, leaf read and check, then a read and an update step per key
//   bit for a walk or a path update; erase of the k-th key does a walk and then a path update
// throughput: one item at a time, with a count memory read per trie level (and a write on a path update)
// reset: a clearing pass writes zero to all 2^(KEY_BITS+1) counters, one per
//   cycle, before the first item is taken
`default_nettype none

module bitwise_trie_multiset import bt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  bt_in_if.sink     in_if,
  bt_out_if.source  out_if
);

  // command and status between sequencer and datapath
  cmd_t    cmd;
  bt_sts_t sts;

  // sequencer: accepts an item only when idle, walks one level per read state and use state
  bt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: count memory, walk state and a result register that holds
  // a finished item while the next one is worked on
  bt_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_req_type (in_if.req_type),
    .in_key      (in_if.key),
    .in_amount   (in_if.amount),
    .out_valid   (out_if.valid),
    .out_ready   (out_if.ready),
    .out_value   (out_if.value),
    .out_tally   (out_if.tally),
    .out_status  (out_if.status)
  );

endmodule

`default_nettype wire
